// ===== rtl/core/lrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrtc_pkg
// Shared constants and types for the thin or capsule line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrtc_pkg;

   localparam int COORD_BITS    = 15;
   localparam int MAX_THICKNESS = 255;

   localparam int TH_W     = 8;
   localparam int COLOUR_W = 32;
   localparam int PIX_W    = COORD_BITS + 1;
   localparam int DEL_W    = COORD_BITS + 1;
   localparam int DIF_W    = COORD_BITS + 2;
   localparam int ERR_W    = COORD_BITS + 3;
   localparam int HW_W     = $clog2(MAX_THICKNESS / 2 + 1);
   localparam int R2_W     = 2 * HW_W;
   localparam int LEN_W    = 2 * COORD_BITS + 2;
   localparam int RL_W     = LEN_W + R2_W;
   localparam int CROSS_W  = 2 * COORD_BITS + 3;
   localparam int SUM_W    = 2 * COORD_BITS + 5;
   localparam int MUL_W    = CROSS_W + 1;
   localparam int PROD_W   = 2 * MUL_W;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_THIN,
      MODE_THICK
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_XX,
      ST_LD_YY,
      ST_LD_R2,
      ST_LD_RL,
      ST_LD_DONE,
      ST_DOT_X,
      ST_DOT_Y,
      ST_BRANCH,
      ST_DST_X,
      ST_DST_Y,
      ST_DST_CMP,
      ST_CRS_A,
      ST_CRS_B,
      ST_CRS_SUB,
      ST_CRS_SQ,
      ST_CRS_CMP,
      ST_EMIT
   } seq_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/lrtc_mul.sv =====
// ----------------------------------------------------------------------------
// lrtc_mul
// Shared signed multiplier with a registered product, one issue per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrtc_mul import lrtc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]      prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer_thin_or_capsule_core.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_thin_or_capsule_core
// Line pixel generator: Bresenham walk for thin lines, capsule coverage scan
// over the widened bounding box for thick lines, one pixel per step request.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    cmd, endpoints, thickness, colour
//   rsp       out   rsp_valid/rsp_ready    pixel x/y, covered, colour, final
//
// Thin step goes straight to ST_EMIT; thick step runs the dot product and then
// ST_DST_* at segment ends or ST_CRS_* in the middle span (one product per cycle).
// Thick load runs ST_LD_XX to ST_LD_DONE (length and radius products).
// req_ready is high only while the sequencer is idle; a pixel waits in the rsp
// register while a new request is taken, and the next one holds until it drains.
// Reset is synchronous; the block comes up idle with no line loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_thin_or_capsule_core import lrtc_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_cmd,
   input  wire logic signed [COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_end_y,
   input  wire logic [TH_W-1:0]               req_line_thickness,
   input  wire logic [COLOUR_W-1:0]           req_colour_in,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [PIX_W-1:0]            rsp_pixel_x,
   output logic signed [PIX_W-1:0]            rsp_pixel_y,
   output logic                               rsp_covered,
   output logic [COLOUR_W-1:0]                rsp_colour_out,
   output logic                               rsp_final_pixel
);

   // control
   seq_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // line registers
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [COORD_BITS-1:0] x0_in, y0_in, x1_in, y1_in;
   logic signed [DEL_W-1:0]      dx_ff, dy_ff, dx_in, dy_in;
   logic [HW_W-1:0]              hw_ff, hw_in;
   logic [R2_W-1:0]              r2_ff, r2_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [RL_W-1:0]              rl_ff, rl_in;
   logic signed [PIX_W-1:0]      bminx_ff, bmaxx_ff, bmaxy_ff;
   logic signed [PIX_W-1:0]      bminx_in, bmaxx_in, bmaxy_in;
   logic signed [PIX_W-1:0]      cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic [COLOUR_W-1:0]          colour_ff, colour_in;

   // per-pixel scratch
   logic signed [SUM_W-1:0]      acc_ff, acc_in;
   logic [CROSS_W-1:0]           c_ff, c_in;
   logic                         sel_end_ff, sel_end_in;
   logic                         cov_ff, cov_in;

   // rsp register
   logic signed [PIX_W-1:0]      rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   logic                         rsp_cov_ff, rsp_cov_in;
   logic [COLOUR_W-1:0]          rsp_colour_ff, rsp_colour_in;
   logic                         rsp_fin_ff, rsp_fin_in;

   // strobes
   logic req_fire, load_go, step_go, emit_go;

   // multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   lrtc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   // ---------------- load-time values ----------------
   logic [TH_W-1:0]              th_sat;
   logic [HW_W-1:0]              hw_new;
   logic                         thin_new;
   logic signed [COORD_BITS-1:0] minx, maxx, miny, maxy;
   logic signed [PIX_W-1:0]      minx_e, maxx_e, miny_e, maxy_e, hw_e;
   logic signed [DEL_W-1:0]      dx_new, dy_new;
   logic [DEL_W-1:0]             dxm_new, dym_new;
   logic signed [ERR_W-1:0]      err_new;

   always_comb begin
      th_sat   = (int'(req_line_thickness) > MAX_THICKNESS) ?
                 TH_W'(MAX_THICKNESS) : req_line_thickness;
      hw_new   = HW_W'(th_sat >> 1);
      thin_new = (th_sat <= TH_W'(1));
      minx     = (req_start_x < req_end_x) ? req_start_x : req_end_x;
      maxx     = (req_start_x > req_end_x) ? req_start_x : req_end_x;
      miny     = (req_start_y < req_end_y) ? req_start_y : req_end_y;
      maxy     = (req_start_y > req_end_y) ? req_start_y : req_end_y;
      minx_e   = PIX_W'(minx);
      maxx_e   = PIX_W'(maxx);
      miny_e   = PIX_W'(miny);
      maxy_e   = PIX_W'(maxy);
      hw_e     = PIX_W'(hw_new);
      dx_new   = DEL_W'(req_end_x) - DEL_W'(req_start_x);
      dy_new   = DEL_W'(req_end_y) - DEL_W'(req_start_y);
      dxm_new  = (dx_new < 0) ? DEL_W'(-dx_new) : DEL_W'(dx_new);
      dym_new  = (dy_new < 0) ? DEL_W'(-dy_new) : DEL_W'(dy_new);
      err_new  = ERR_W'(dxm_new) - ERR_W'(dym_new);
   end

   // ---------------- pixel datapath values ----------------
   logic signed [DIF_W-1:0]  px, py, ex, ey, qx, qy;
   logic signed [SUM_W-1:0]  p_sum, p_diff, len_s, r2_s;
   logic                     use_end, use_cross;

   always_comb begin
      px     = DIF_W'(cur_x_ff) - DIF_W'(x0_ff);
      py     = DIF_W'(cur_y_ff) - DIF_W'(y0_ff);
      ex     = DIF_W'(cur_x_ff) - DIF_W'(x1_ff);
      ey     = DIF_W'(cur_y_ff) - DIF_W'(y1_ff);
      qx     = sel_end_ff ? ex : px;
      qy     = sel_end_ff ? ey : py;
      p_sum  = acc_ff + SUM_W'(mul_p);
      p_diff = acc_ff - SUM_W'(mul_p);
      len_s  = SUM_W'(len_ff);
      r2_s   = SUM_W'(r2_ff);
      use_end   = (len_ff != '0) && (p_sum > 0) && (p_sum >= len_s);
      use_cross = (len_ff != '0) && (p_sum > 0) && (p_sum < len_s);
   end

   // ---------------- step commit values ----------------
   logic [DEL_W-1:0]         dxm_cur, dym_cur;
   logic signed [ERR_W:0]    e2, dxp, dyp, dyn, e_sum;
   logic                     stx, sty;
   logic signed [PIX_W-1:0]  x_walk, y_walk;
   logic                     thin_fin, thick_fin, fin;

   always_comb begin
      dxm_cur   = (dx_ff < 0) ? DEL_W'(-dx_ff) : DEL_W'(dx_ff);
      dym_cur   = (dy_ff < 0) ? DEL_W'(-dy_ff) : DEL_W'(dy_ff);
      e2        = {err_ff, 1'b0};
      dxp       = (ERR_W+1)'(dxm_cur);
      dyp       = (ERR_W+1)'(dym_cur);
      dyn       = -dyp;
      stx       = (e2 >= dyn);
      sty       = (e2 <= dxp);
      e_sum     = (ERR_W+1)'(err_ff) + (stx ? dyn : '0) + (sty ? dxp : '0);
      x_walk    = (dx_ff > 0) ? cur_x_ff + PIX_W'(1) : cur_x_ff - PIX_W'(1);
      y_walk    = (dy_ff > 0) ? cur_y_ff + PIX_W'(1) : cur_y_ff - PIX_W'(1);
      thin_fin  = (cur_x_ff == PIX_W'(x1_ff)) && (cur_y_ff == PIX_W'(y1_ff));
      thick_fin = (cur_x_ff >= bmaxx_ff) && (cur_y_ff >= bmaxy_ff);
      fin       = (mode_ff == MODE_THIN) ? thin_fin : thick_fin;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_go) begin
               state_in = thin_new ? ST_IDLE : ST_LD_XX;
            end else if (step_go) begin
               state_in = (mode_ff == MODE_THIN) ? ST_EMIT : ST_DOT_X;
            end
         end
         ST_LD_XX:   state_in = ST_LD_YY;
         ST_LD_YY:   state_in = ST_LD_R2;
         ST_LD_R2:   state_in = ST_LD_RL;
         ST_LD_RL:   state_in = ST_LD_DONE;
         ST_LD_DONE: state_in = ST_IDLE;
         ST_DOT_X:   state_in = ST_DOT_Y;
         ST_DOT_Y:   state_in = ST_BRANCH;
         ST_BRANCH:  state_in = use_cross ? ST_CRS_A : ST_DST_X;
         ST_DST_X:   state_in = ST_DST_Y;
         ST_DST_Y:   state_in = ST_DST_CMP;
         ST_DST_CMP: state_in = ST_EMIT;
         ST_CRS_A:   state_in = ST_CRS_B;
         ST_CRS_B:   state_in = ST_CRS_SUB;
         ST_CRS_SUB: state_in = ST_CRS_SQ;
         ST_CRS_SQ:  state_in = ST_CRS_CMP;
         ST_CRS_CMP: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_fire  = req_valid && req_ready;
      load_go   = req_fire && (req_cmd == CMD_LOAD);
      step_go   = req_fire && (req_cmd == CMD_STEP) && (mode_ff != MODE_IDLE);
      emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LD_XX: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         ST_LD_YY: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(dy_ff);
         end
         ST_LD_R2: begin
            mul_a = MUL_W'(hw_ff);
            mul_b = MUL_W'(hw_ff);
         end
         ST_LD_RL: begin
            mul_a = MUL_W'(mul_p[R2_W-1:0]);
            mul_b = MUL_W'(len_ff);
         end
         ST_DOT_X: begin
            mul_a = MUL_W'(px);
            mul_b = MUL_W'(dx_ff);
         end
         ST_DOT_Y: begin
            mul_a = MUL_W'(py);
            mul_b = MUL_W'(dy_ff);
         end
         ST_DST_X: begin
            mul_a = MUL_W'(qx);
            mul_b = MUL_W'(qx);
         end
         ST_DST_Y: begin
            mul_a = MUL_W'(qy);
            mul_b = MUL_W'(qy);
         end
         ST_CRS_A: begin
            mul_a = MUL_W'(px);
            mul_b = MUL_W'(dy_ff);
         end
         ST_CRS_B: begin
            mul_a = MUL_W'(py);
            mul_b = MUL_W'(dx_ff);
         end
         ST_CRS_SQ: begin
            mul_a = MUL_W'(c_ff);
            mul_b = MUL_W'(c_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      mode_in       = mode_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      hw_in         = hw_ff;
      r2_in         = r2_ff;
      len_in        = len_ff;
      rl_in         = rl_ff;
      bminx_in      = bminx_ff;
      bmaxx_in      = bmaxx_ff;
      bmaxy_in      = bmaxy_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      err_in        = err_ff;
      colour_in     = colour_ff;
      acc_in        = acc_ff;
      c_in          = c_ff;
      sel_end_in    = sel_end_ff;
      cov_in        = cov_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_cov_in    = rsp_cov_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (load_go) begin
         x0_in     = req_start_x;
         y0_in     = req_start_y;
         x1_in     = req_end_x;
         y1_in     = req_end_y;
         dx_in     = dx_new;
         dy_in     = dy_new;
         hw_in     = hw_new;
         colour_in = req_colour_in;
         if (thin_new) begin
            mode_in  = MODE_THIN;
            cur_x_in = PIX_W'(req_start_x);
            cur_y_in = PIX_W'(req_start_y);
            err_in   = err_new;
         end else begin
            mode_in  = MODE_THICK;
            bminx_in = minx_e - hw_e;
            bmaxx_in = maxx_e + hw_e;
            bmaxy_in = maxy_e + hw_e;
            cur_x_in = minx_e - hw_e;
            cur_y_in = miny_e - hw_e;
            err_in   = '0;
         end
      end

      unique case (state_ff) inside
         ST_LD_YY, ST_DOT_Y, ST_DST_Y, ST_CRS_B: begin
            acc_in = SUM_W'(mul_p);
         end
         ST_LD_R2:   len_in = LEN_W'(p_sum);
         ST_LD_RL:   r2_in = mul_p[R2_W-1:0];
         ST_LD_DONE: rl_in = mul_p[RL_W-1:0];
         ST_BRANCH:  sel_end_in = use_end;
         ST_DST_CMP: cov_in = (p_sum <= r2_s);
         ST_CRS_SUB: c_in = (p_diff < 0) ? CROSS_W'(-p_diff) : CROSS_W'(p_diff);
         ST_CRS_CMP: cov_in = ($unsigned(mul_p) <= PROD_W'(rl_ff));
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = cur_x_ff;
               rsp_y_in      = cur_y_ff;
               rsp_cov_in    = (mode_ff == MODE_THIN) ? 1'b1 : cov_ff;
               rsp_colour_in = colour_ff;
               rsp_fin_in    = fin;
               if (fin) begin
                  mode_in = MODE_IDLE;
               end else if (mode_ff == MODE_THIN) begin
                  err_in = ERR_W'(e_sum);
                  if (stx) begin
                     cur_x_in = x_walk;
                  end
                  if (sty) begin
                     cur_y_in = y_walk;
                  end
               end else if (cur_x_ff >= bmaxx_ff) begin
                  cur_x_in = bminx_ff;
                  cur_y_in = cur_y_ff + PIX_W'(1);
               end else begin
                  cur_x_in = cur_x_ff + PIX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      hw_ff         <= hw_in;
      r2_ff         <= r2_in;
      len_ff        <= len_in;
      rl_ff         <= rl_in;
      bminx_ff      <= bminx_in;
      bmaxx_ff      <= bmaxx_in;
      bmaxy_ff      <= bmaxy_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      err_ff        <= err_in;
      colour_ff     <= colour_in;
      acc_ff        <= acc_in;
      c_ff          <= c_in;
      sel_end_ff    <= sel_end_in;
      cov_ff        <= cov_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_cov_ff    <= rsp_cov_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_covered     = rsp_cov_ff;
   assign rsp_colour_out  = rsp_colour_ff;
   assign rsp_final_pixel = rsp_fin_ff;

   // ---------------- assertions ----------------
   a_thick_cursor_in_box: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_THICK) |-> (cur_x_ff >= bminx_ff) && (cur_x_ff <= bmaxx_ff))
      else $error("thick cursor left the bounding box");

   a_final_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_go && fin) |=> (mode_ff == MODE_IDLE))
      else $error("line still active after final pixel");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && ($past(state_ff) != ST_EMIT)) |->
         (($past(state_ff) == ST_DST_CMP) || ($past(state_ff) == ST_CRS_CMP) ||
          (($past(state_ff) == ST_IDLE) && (mode_ff == MODE_THIN))))
      else $error("pixel emitted without a finished coverage test");

endmodule

`default_nettype wire
